@@ rtl/glyph_coverage_blend_macros.svh @@
// ----------------------------------------------------------------------------
// Glyph coverage blend assertion macros
// Shared concurrent assertion wrappers; defining ASSERT_OFF leaves them empty.
// ----------------------------------------------------------------------------
`ifndef GLYPH_COVERAGE_BLEND_MACROS_SVH
`define GLYPH_COVERAGE_BLEND_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge outside reset.
`define GCB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define GCB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define GCB_ASSERT(label, prop, msg)
`define GCB_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ rtl/gcb_pkg.sv @@
// ----------------------------------------------------------------------------
// Glyph coverage blend package
// Register codes, coverage formats, draw modes and the channel mix function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcb_pkg;

    localparam int CHAN_W    = 8;
    localparam int RATE_W    = CHAN_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 32;

    // Rate that means full coverage
    localparam logic [RATE_W-1:0] RATE_FULL = 9'd256;

    // Highest gray level of each gray format
    localparam logic [CHAN_W-1:0] MAX_GRAY5  = 8'd4;
    localparam logic [CHAN_W-1:0] MAX_GRAY17 = 8'd16;
    localparam logic [CHAN_W-1:0] MAX_GRAY65 = 8'd64;

    localparam logic [CFG_IDX_W-1:0] REG_COVERAGE_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_RED        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_GREEN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_BLUE       = 3'd4;

    typedef enum logic [1:0] {
        FMT_MONO   = 2'd0,
        FMT_GRAY5  = 2'd1,
        FMT_GRAY17 = 2'd2,
        FMT_GRAY65 = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        MODE_COLOR  = 2'd0,
        MODE_PREMUL = 2'd1,
        MODE_ALPHA  = 2'd2,
        MODE_GRAY   = 2'd3
    } mode_t;

    // (d * (256 - rate) >> 8) + (s * rate >> 8); the sum never exceeds 255
    function automatic logic [CHAN_W-1:0] mix(
        input logic [CHAN_W-1:0] d,
        input logic [CHAN_W-1:0] s,
        input logic [RATE_W-1:0] rate
    );
        logic [RATE_W-1:0]          inv;
        logic [CHAN_W+RATE_W-1:0]   pd;
        logic [CHAN_W+RATE_W-1:0]   ps;
        logic [RATE_W:0]            sum;
        inv = RATE_FULL - rate;
        pd  = {{RATE_W{1'b0}}, d} * {{CHAN_W{1'b0}}, inv};
        ps  = {{RATE_W{1'b0}}, s} * {{CHAN_W{1'b0}}, rate};
        sum = {1'b0, pd[CHAN_W+RATE_W-1:CHAN_W]} + {1'b0, ps[CHAN_W+RATE_W-1:CHAN_W]};
        return sum[CHAN_W-1:0];
    endfunction

endpackage

@@ rtl/glyph_coverage_blend.sv @@
// ----------------------------------------------------------------------------
// Glyph coverage blend
// Blends a text color into an RGBA pixel stream by per-pixel glyph coverage.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid / s_tready   sample, bit select, dest RGBA
//  m_*       out        m_tvalid / m_tready   blended RGBA
//  cfg_*     in         cfg_valid / cfg_ready register index, 8-bit data
//
//  One pixel per clock sustained while m_tready stays high; the path runs from the input
//  register to the result register, with the coverage decode and four channel mixes between them.
//  Reset clears both valid flags and the config registers to mode 0, format 0, black.
//  A stalled result holds in the output register while one more pixel waits in
//  the input register; cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "glyph_coverage_blend_macros.svh"

module glyph_coverage_blend (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] glyph_sample, [10:8] bit_select, [18:11] dest_red,
    // [26:19] dest_green, [34:27] dest_blue, [42:35] dest_alpha, [47:43] zero
    input  logic [gcb_pkg::S_DATA_W-1:0]      s_tdata,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha
    output logic [gcb_pkg::M_DATA_W-1:0]      m_tdata,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gcb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gcb_pkg::CHAN_W-1:0]        cfg_data
);

    gcb_pkg::fmt_t                  coverage_format_reg;
    gcb_pkg::mode_t                 draw_mode_reg;
    logic [gcb_pkg::CHAN_W-1:0]     text_red_reg;
    logic [gcb_pkg::CHAN_W-1:0]     text_green_reg;
    logic [gcb_pkg::CHAN_W-1:0]     text_blue_reg;

    logic                           s1_valid_reg;
    logic [gcb_pkg::CHAN_W-1:0]     s1_sample_reg;
    logic [2:0]                     s1_sel_reg;
    logic [gcb_pkg::CHAN_W-1:0]     s1_red_reg;
    logic [gcb_pkg::CHAN_W-1:0]     s1_green_reg;
    logic [gcb_pkg::CHAN_W-1:0]     s1_blue_reg;
    logic [gcb_pkg::CHAN_W-1:0]     s1_alpha_reg;

    logic                           out_valid_reg;
    logic [gcb_pkg::M_DATA_W-1:0]   out_data_reg;
    logic [gcb_pkg::M_DATA_W-1:0]   out_data_next;

    logic                           s1_advance;
    logic [2:0]                     bit_pos;
    logic                           mono_bit;
    logic [6:0]                     lvl;
    logic [gcb_pkg::RATE_W-1:0]     rate;
    logic [gcb_pkg::RATE_W-1:0]     gray_full;
    logic [gcb_pkg::CHAN_W-1:0]     gray;
    logic [gcb_pkg::CHAN_W-1:0]     mix_red;
    logic [gcb_pkg::CHAN_W-1:0]     mix_green;
    logic [gcb_pkg::CHAN_W-1:0]     mix_blue;
    logic [gcb_pkg::CHAN_W-1:0]     mix_alpha;
    logic [gcb_pkg::CHAN_W-1:0]     res_red;
    logic [gcb_pkg::CHAN_W-1:0]     res_green;
    logic [gcb_pkg::CHAN_W-1:0]     res_blue;
    logic [gcb_pkg::CHAN_W-1:0]     res_alpha;

    assign cfg_ready  = 1'b1;
    assign s1_advance = !out_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coverage_format_reg <= gcb_pkg::FMT_MONO;
            draw_mode_reg       <= gcb_pkg::MODE_COLOR;
            text_red_reg        <= '0;
            text_green_reg      <= '0;
            text_blue_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gcb_pkg::REG_COVERAGE_FORMAT:
                    coverage_format_reg <= gcb_pkg::fmt_t'(cfg_data[1:0]);
                gcb_pkg::REG_DRAW_MODE:
                    draw_mode_reg <= gcb_pkg::mode_t'(cfg_data[1:0]);
                gcb_pkg::REG_TEXT_RED:   text_red_reg   <= cfg_data;
                gcb_pkg::REG_TEXT_GREEN: text_green_reg <= cfg_data;
                gcb_pkg::REG_TEXT_BLUE:  text_blue_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_sample_reg <= s_tdata[7:0];
            s1_sel_reg    <= s_tdata[10:8];
            s1_red_reg    <= s_tdata[18:11];
            s1_green_reg  <= s_tdata[26:19];
            s1_blue_reg   <= s_tdata[34:27];
            s1_alpha_reg  <= s_tdata[42:35];
        end
    end

    // Coverage decode
    always_comb
    begin
        bit_pos   = 3'd7 - s1_sel_reg;
        mono_bit  = s1_sample_reg[bit_pos];
        lvl       = '0;
        rate      = '0;
        gray_full = '0;
        unique case (coverage_format_reg)
            gcb_pkg::FMT_MONO:
            begin
                rate      = mono_bit ? gcb_pkg::RATE_FULL : '0;
                gray_full = mono_bit ? 9'd255 : 9'd0;
            end
            gcb_pkg::FMT_GRAY5:
            begin
                lvl       = (s1_sample_reg > gcb_pkg::MAX_GRAY5)
                            ? gcb_pkg::MAX_GRAY5[6:0] : s1_sample_reg[6:0];
                rate      = {lvl[2:0], 6'd0};
                gray_full = rate - 9'(lvl >> 2);
            end
            gcb_pkg::FMT_GRAY17:
            begin
                lvl       = (s1_sample_reg > gcb_pkg::MAX_GRAY17)
                            ? gcb_pkg::MAX_GRAY17[6:0] : s1_sample_reg[6:0];
                rate      = {lvl[4:0], 4'd0};
                gray_full = rate - 9'(lvl >> 4);
            end
            gcb_pkg::FMT_GRAY65:
            begin
                lvl       = (s1_sample_reg > gcb_pkg::MAX_GRAY65)
                            ? gcb_pkg::MAX_GRAY65[6:0] : s1_sample_reg[6:0];
                rate      = {lvl, 2'd0};
                gray_full = rate - 9'(lvl >> 6);
            end
            default: ;
        endcase
        gray = gray_full[gcb_pkg::CHAN_W-1:0];
    end

    assign mix_red   = gcb_pkg::mix(s1_red_reg, text_red_reg, rate);
    assign mix_green = gcb_pkg::mix(s1_green_reg, text_green_reg, rate);
    assign mix_blue  = gcb_pkg::mix(s1_blue_reg, text_blue_reg, rate);
    assign mix_alpha = gcb_pkg::mix(s1_alpha_reg, 8'hFF, rate);

    // Mode select
    always_comb
    begin
        res_red   = s1_red_reg;
        res_green = s1_green_reg;
        res_blue  = s1_blue_reg;
        res_alpha = s1_alpha_reg;
        unique case (draw_mode_reg)
            gcb_pkg::MODE_COLOR:
            begin
                res_red   = mix_red;
                res_green = mix_green;
                res_blue  = mix_blue;
            end
            gcb_pkg::MODE_PREMUL:
            begin
                res_red   = mix_red;
                res_green = mix_green;
                res_blue  = mix_blue;
                res_alpha = mix_alpha;
            end
            gcb_pkg::MODE_ALPHA:
            begin
                res_alpha = mix_alpha;
            end
            gcb_pkg::MODE_GRAY:
            begin
                res_alpha = gray;
            end
            default: ;
        endcase
        out_data_next = {res_alpha, res_blue, res_green, res_red};
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `GCB_ASSERT(a_accept_fills_stage, (s_tvalid && s_tready) |=> s1_valid_reg, "accepted pixel lost before the blend stage")
    `GCB_ASSERT(a_full_blocks_input, (s1_valid_reg && m_tvalid && !m_tready) |-> !s_tready, "input taken while both stages are full and stalled")
    `GCB_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (!m_tvalid && !s1_valid_reg), "pipeline not empty after reset")

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Glyph coverage blend testbench
// Drives pixel transfers and register writes into glyph_coverage_blend and
// compares every output pixel with a local blend predictor. Directed cases
// cover the coverage formats and draw modes. Random phases then run with
// sender and receiver idling, a long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEMS_PER_SET = 30;

    typedef struct packed {
        logic [7:0] da;
        logic [7:0] db;
        logic [7:0] dg;
        logic [7:0] dr;
        logic [2:0] bit_sel;
        logic [7:0] sample;
    } glyph_px_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } rgba_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [gcb_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [gcb_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [gcb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gcb_pkg::CHAN_W-1:0]     cfg_data = '0;

    // local copy of the block's registers
    gcb_pkg::fmt_t   cur_fmt = gcb_pkg::FMT_MONO;
    gcb_pkg::mode_t  cur_mode = gcb_pkg::MODE_COLOR;
    logic [7:0]      text_r = 8'd0;
    logic [7:0]      text_g = 8'd0;
    logic [7:0]      text_b = 8'd0;

    rgba_t       expected_px_q[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_cycles = 0;

    glyph_coverage_blend i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("FAIL glyph_coverage_blend");
                $finish;
            end
        end
    end

    function automatic int blend_chan(int d, int s, int rate);
        return (((d * (256 - rate)) >> 8) + ((s * rate) >> 8)) & 255;
    endfunction

    function automatic rgba_t predict_blend(glyph_px_t px);
        int    rate;
        int    gray;
        int    q2;
        int    lvl;
        int    max_lvl;
        int    sel;
        rgba_t res;
        if (cur_fmt == gcb_pkg::FMT_MONO)
        begin
            sel  = int'(px.bit_sel);
            rate = px.sample[7 - sel] ? 256 : 0;
            gray = px.sample[7 - sel] ? 255 : 0;
        end
        else
        begin
            q2      = 2 * int'(cur_fmt);
            max_lvl = 1 << q2;
            lvl     = (int'(px.sample) > max_lvl) ? max_lvl : int'(px.sample);
            rate    = lvl << (8 - q2);
            gray    = (rate - (lvl >> q2)) & 255;
        end
        res = '{a: px.da, b: px.db, g: px.dg, r: px.dr};
        case (cur_mode)
            gcb_pkg::MODE_COLOR:
            begin
                res.r = 8'(blend_chan(int'(px.dr), int'(text_r), rate));
                res.g = 8'(blend_chan(int'(px.dg), int'(text_g), rate));
                res.b = 8'(blend_chan(int'(px.db), int'(text_b), rate));
            end
            gcb_pkg::MODE_PREMUL:
            begin
                res.r = 8'(blend_chan(int'(px.dr), int'(text_r), rate));
                res.g = 8'(blend_chan(int'(px.dg), int'(text_g), rate));
                res.b = 8'(blend_chan(int'(px.db), int'(text_b), rate));
                res.a = 8'(blend_chan(int'(px.da), 255, rate));
            end
            gcb_pkg::MODE_ALPHA:
            begin
                res.a = 8'(blend_chan(int'(px.da), 255, rate));
            end
            default:
            begin
                res.a = 8'(gray);
            end
        endcase
        return res;
    endfunction

    function automatic logic [7:0] rand_chan();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 8'd0;
        else if (pick == 1)
            return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    // gray levels stay mostly within the format's range, with some saturation
    function automatic logic [7:0] rand_sample();
        int pick;
        int max_lvl;
        if (cur_fmt == gcb_pkg::FMT_MONO)
            return 8'($urandom_range(255));
        max_lvl = 1 << (2 * int'(cur_fmt));
        pick = $urandom_range(9);
        if (pick <= 6)
            return 8'($urandom_range(max_lvl));
        else if (pick == 7)
            return 8'(max_lvl + int'($urandom_range(1, 3)));
        return 8'($urandom_range(255));
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        mismatch_count = mismatch_count + 1;
    endtask

    task automatic send_pixel(input logic [7:0] sample, input logic [2:0] sel,
                              input logic [7:0] dr, input logic [7:0] dg,
                              input logic [7:0] db, input logic [7:0] da);
        glyph_px_t px;
        int        gap;
        px  = '{da: da, db: db, dg: dg, dr: dr, bit_sel: sel, sample: sample};
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap = gap + 1;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, px};
        do
            @(posedge clk);
        while (!s_tready);
        expected_px_q.push_back(predict_blend(px));
    endtask

    task automatic send_random_pixel();
        send_pixel(rand_sample(), 3'($urandom_range(7)), rand_chan(), rand_chan(),
                   rand_chan(), rand_chan());
    endtask

    // hold the input until every expected pixel is back, then let the pipe settle
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_px_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gcb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            gcb_pkg::REG_COVERAGE_FORMAT: cur_fmt = gcb_pkg::fmt_t'(val[1:0]);
            gcb_pkg::REG_DRAW_MODE:       cur_mode = gcb_pkg::mode_t'(val[1:0]);
            gcb_pkg::REG_TEXT_RED:        text_r = val;
            gcb_pkg::REG_TEXT_GREEN:      text_g = val;
            gcb_pkg::REG_TEXT_BLUE:       text_b = val;
            default:                      ;
        endcase
    endtask

    task automatic load_setup(input gcb_pkg::fmt_t fmt, input gcb_pkg::mode_t mode,
                              input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        wait_drain();
        write_reg(gcb_pkg::REG_COVERAGE_FORMAT, {6'd0, fmt});
        write_reg(gcb_pkg::REG_DRAW_MODE, {6'd0, mode});
        write_reg(gcb_pkg::REG_TEXT_RED, r);
        write_reg(gcb_pkg::REG_TEXT_GREEN, g);
        write_reg(gcb_pkg::REG_TEXT_BLUE, b);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_pixel(8'hFF, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 3'd7, 8'hAA, 8'h55, 8'h00, 8'h80);
    endtask

    task automatic test_mono_modes();
        // premultiplied: a set bit forces alpha to full
        load_setup(gcb_pkg::FMT_MONO, gcb_pkg::MODE_PREMUL, 8'd255, 8'd0, 8'd128);
        send_pixel(8'h80, 3'd0, 8'h12, 8'h34, 8'h56, 8'h01);
        send_pixel(8'h7F, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h01, 3'd7, 8'h00, 8'h00, 8'h00, 8'h00);
        load_setup(gcb_pkg::FMT_MONO, gcb_pkg::MODE_GRAY, 8'd0, 8'd255, 8'd0);
        send_pixel(8'hFF, 3'd3, 8'h0F, 8'hF0, 8'h3C, 8'h00);
        send_pixel(8'hEF, 3'd3, 8'h11, 8'h22, 8'h33, 8'hFF);
    endtask

    task automatic test_gray_levels();
        // bit select must have no effect in the gray formats
        load_setup(gcb_pkg::FMT_GRAY5, gcb_pkg::MODE_COLOR, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 3'd7, 8'hFF, 8'h00, 8'h80, 8'h40);
        send_pixel(8'd2, 3'd0, 8'h00, 8'hFF, 8'h7F, 8'hC0);
        send_pixel(8'd4, 3'd5, 8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(8'd5, 3'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'd255, 3'd6, 8'h01, 8'h02, 8'h03, 8'h04);
        load_setup(gcb_pkg::FMT_GRAY17, gcb_pkg::MODE_ALPHA, 8'd10, 8'd20, 8'd30);
        send_pixel(8'd16, 3'd1, 8'h55, 8'hAA, 8'h55, 8'h00);
        send_pixel(8'd17, 3'd4, 8'h55, 8'hAA, 8'h55, 8'h80);
        send_pixel(8'd8, 3'd0, 8'hAA, 8'h55, 8'hAA, 8'h81);
        load_setup(gcb_pkg::FMT_GRAY65, gcb_pkg::MODE_GRAY, 8'd255, 8'd0, 8'd255);
        send_pixel(8'd64, 3'd0, 8'h10, 8'h20, 8'h30, 8'h00);
        send_pixel(8'd65, 3'd7, 8'h10, 8'h20, 8'h30, 8'hFF);
        send_pixel(8'd1, 3'd3, 8'hFE, 8'hFD, 8'hFC, 8'h7F);
        send_pixel(8'd33, 3'd2, 8'h00, 8'hFF, 8'h00, 8'h3A);
        send_pixel(8'd255, 3'd5, 8'hFF, 8'h00, 8'hFF, 8'h99);
    endtask

    task automatic test_backpressure();
        load_setup(gcb_pkg::FMT_GRAY17, gcb_pkg::MODE_PREMUL, rand_chan(), rand_chan(),
                   rand_chan());
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 300;
        repeat (40) send_random_pixel();
        wait_drain();
    endtask

    // every format meets every draw mode across the four phases
    task automatic test_random_phase(input int phase, input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (int k = 0; k < 4; k++)
        begin
            load_setup(gcb_pkg::fmt_t'(k), gcb_pkg::mode_t'((k + phase) % 4),
                       rand_chan(), rand_chan(), rand_chan());
            repeat (ITEMS_PER_SET) send_random_pixel();
        end
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        rgba_t got;
        rgba_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_px_q.size() == 0)
            begin
                report_mismatch("unexpected pixel", int'(got), 0);
            end
            else
            begin
                want = expected_px_q.pop_front();
                if (got.r !== want.r)
                    report_mismatch("out_red", int'(got.r), int'(want.r));
                if (got.g !== want.g)
                    report_mismatch("out_green", int'(got.g), int'(want.g));
                if (got.b !== want.b)
                    report_mismatch("out_blue", int'(got.b), int'(want.b));
                if (got.a !== want.a)
                    report_mismatch("out_alpha", int'(got.a), int'(want.a));
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_mono_modes();
        test_gray_levels();
        test_random_phase(0, 0, 0);
        test_random_phase(1, 86, 0);
        test_random_phase(2, 0, 86);
        test_random_phase(3, 27, 27);
        test_backpressure();

        wait_drain();
        repeat (10) @(posedge clk);
        if (expected_px_q.size() != 0)
            report_mismatch("pixels never returned", 0, expected_px_q.size());
        if (mismatch_count == 0)
            $display("PASS glyph_coverage_blend");
        else
            $display("FAIL glyph_coverage_blend");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/gcb_pkg.sv
rtl/glyph_coverage_blend.sv
bench/testbench.sv
